// ----- src/qrs_pkg.sv -----
// Shared constants for the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
  localparam int WORD_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int EPS_W             = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 32;
  localparam logic REG_EPSILON     = 1'b0;   // register index taken from paddr[2]
  localparam logic [1:0] CNT_NONE  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
endpackage
`default_nettype wire

// ----- src/quadratic_root_solver_top.sv -----
// Top level of the pipelined fixed-point quadratic root solver.
// Pipeline stages from input beat to result:
//   three front stages, WORD_BITS+1 square-root stages, one stage, WORD_BITS+FRACTION_BITS+2
//   divider stages, the divider's saturation register and the output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n low, synchronous) clears all valid bits and sets epsilon to 1.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_top #(
  parameter int WORD_BITS     = qrs_pkg::WORD_BITS_DEF,
  parameter int FRACTION_BITS = qrs_pkg::FRACTION_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // in_tdata: coef_a, coef_b, coef_c (WORD_BITS each, signed), zero pad to bytes
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [((3*WORD_BITS+7)/8)*8-1:0]      in_tdata,
  // out_tdata: root_count[2], first_root, second_root, overflow[1], zero pad to bytes
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [((2*WORD_BITS+3+7)/8)*8-1:0]         out_tdata,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [qrs_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  wire logic [qrs_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [qrs_pkg::CFG_DATA_W-1:0]             cfg_prdata,
  output logic                                       cfg_pready
);
  import qrs_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRACTION_BITS;
  localparam int OW   = ((2*W+3+7)/8)*8;
  localparam int DW   = 2*W + 2;
  localparam int RW   = DW / 2;
  localparam int QW   = W + 2;
  localparam int NW   = QW + F;
  localparam int DENW = W + 2;
  localparam int TW   = EPS_W + F;
  localparam int CW   = (DW > TW) ? DW : TW;
  localparam int SW   = 3*W + 5;
  localparam int DL   = NW + 1;

  // configuration
  logic [EPS_W-1:0] eps_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_EPSILON) begin
      eps_r <= cfg_pwdata[EPS_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_EPSILON) ?
                      {{(CFG_DATA_W-EPS_W){1'b0}}, eps_r} : '0;

  logic out_v_r;
  logic en;
  assign en = !out_v_r || out_tready;
  assign in_tready = en;

  // stage 1: signs, magnitudes, |b| test
  logic         v1_r, sa1_r, sb1_r, sc1_r, big1_r;
  logic [W-1:0] ma1_r, mb1_r, mc1_r;
  logic [W-1:0] va, vb, vc;
  assign va = in_tdata[W-1:0];
  assign vb = in_tdata[2*W-1:W];
  assign vc = in_tdata[3*W-1:2*W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
    if (en) begin
      sa1_r <= va[W-1];
      sb1_r <= vb[W-1];
      sc1_r <= vc[W-1];
      ma1_r <= va[W-1] ? W'(-va) : va;
      mb1_r <= vb[W-1] ? W'(-vb) : vb;
      mc1_r <= vc[W-1] ? W'(-vc) : vc;
      big1_r <= (vb[W-1] ? W'(-vb) : vb) > {{(W-EPS_W){1'b0}}, eps_r};
    end
  end

  // stage 2: products
  logic           v2_r, sa2_r, sb2_r, sc2_r, big2_r;
  logic [W-1:0]   ma2_r, mb2_r, mc2_r;
  logic [2*W-1:0] bb2_r, ac2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      bb2_r <= mb1_r * mb1_r;
      ac2_r <= ma1_r * mc1_r;
      {sa2_r, sb2_r, sc2_r, big2_r} <= {sa1_r, sb1_r, sc1_r, big1_r};
      {ma2_r, mb2_r, mc2_r} <= {ma1_r, mb1_r, mc1_r};
    end
  end

  // stage 3: discriminant and the no-root test
  logic [DW-1:0] bbw, ac4, disc_nxt;
  logic          none_nxt;
  always_comb begin
    bbw = {2'b00, bb2_r};
    ac4 = {ac2_r, 2'b00};
    none_nxt = 1'b0;
    if (sa2_r != sc2_r) begin
      disc_nxt = bbw + ac4;
    end else if (bbw < ac4) begin
      none_nxt = 1'b1;
      disc_nxt = bbw;
    end else begin
      disc_nxt = bbw - ac4;
    end
    if (CW'(disc_nxt) < (CW'(eps_r) << F)) begin
      none_nxt = 1'b1;
    end
  end

  logic          v3_r;
  logic [DW-1:0] disc3_r;
  logic [SW-1:0] side3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      disc3_r <= disc_nxt;
      side3_r <= {ma2_r, mb2_r, mc2_r, sa2_r, sb2_r, sc2_r, big2_r, none_nxt};
    end
  end

  logic          v4;
  logic [RW-1:0] root4;
  logic [SW-1:0] side4;
  qrs_sqrt #(.DW(DW), .SW(SW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(v3_r), .in_d(disc3_r), .in_side(side3_r),
    .out_v(v4), .out_root(root4), .out_side(side4)
  );

  // stage after the root: q, numerators, denominators, signs
  logic [W-1:0] ma4, mb4, mc4;
  logic         sa4, sb4, sc4, big4, none4, qneg4;
  logic [QW-1:0] mq4;
  assign {ma4, mb4, mc4, sa4, sb4, sc4, big4, none4} = side4;
  assign qneg4 = !sb4;
  assign mq4 = QW'(mb4) + QW'(root4);

  logic            v5_r, neg1_r, neg2_r, big5_r, none5_r;
  logic [NW-1:0]   num1_r, num2_r;
  logic [DENW-1:0] den1_r, den2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4;
    end
    if (en) begin
      num1_r <= big4 ? (NW'(mq4) << F) : (NW'(root4) << F);
      den1_r <= DENW'(ma4) << 1;
      neg1_r <= big4 ? (qneg4 != sa4) : sa4;
      num2_r <= NW'(mc4) << (F + 1);
      den2_r <= DENW'(mq4);
      neg2_r <= sc4 != qneg4;
      big5_r <= big4;
      none5_r <= none4;
    end
  end

  logic [W-1:0] q1, q2;
  logic         ovf1, ovf2;
  qrs_div #(.NW(NW), .DENW(DENW), .W(W)) u_div_first (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v5_r),
    .in_num(num1_r), .in_den(den1_r), .in_neg(neg1_r),
    .out_q(q1), .out_ovf(ovf1)
  );
  qrs_div #(.NW(NW), .DENW(DENW), .W(W)) u_div_second (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v5_r),
    .in_num(num2_r), .in_den(den2_r), .in_neg(neg2_r),
    .out_q(q2), .out_ovf(ovf2)
  );

  // carry the valid bit and case flags beside the dividers
  logic dv_r [DL];
  logic dbig_r [DL];
  logic dnone_r [DL];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) dv_r[i] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= v5_r;
      for (int i = 1; i < DL; i++) dv_r[i] <= dv_r[i-1];
    end
    if (en) begin
      dbig_r[0] <= big5_r;
      dnone_r[0] <= none5_r;
      for (int i = 1; i < DL; i++) begin
        dbig_r[i] <= dbig_r[i-1];
        dnone_r[i] <= dnone_r[i-1];
      end
    end
  end

  // output register
  logic [1:0]   cnt_r;
  logic [W-1:0] r1_r, r2_r;
  logic         ovf_r;
  logic         bigl, nonel;
  assign bigl = dbig_r[DL-1];
  assign nonel = dnone_r[DL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_r[DL-1];
    end
    if (en) begin
      cnt_r <= nonel ? CNT_NONE : (bigl ? CNT_TWO : CNT_ONE);
      r1_r <= nonel ? '0 : q1;
      r2_r <= (nonel || !bigl) ? '0 : q2;
      ovf_r <= !nonel && (ovf1 || (bigl && ovf2));
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {{(OW-2*W-3){1'b0}}, ovf_r, r2_r, r1_r, cnt_r};

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready does not follow output");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != 2'd3) else $error("bad root count");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cnt_r == CNT_NONE) |-> (r1_r == '0 && r2_r == '0 && !ovf_r))
    else $error("no-root result not cleared");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cnt_r == CNT_ONE) |-> r2_r == '0) else $error("second root on single");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(dv_r[DL-1]) && $stable(v5_r))
    else $error("pipeline moved during stall");
endmodule
`default_nettype wire

// ----- src/qrs_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt #(
  parameter int DW = 66,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire logic [DW-1:0] in_d,
  input  wire logic [SW-1:0] in_side,
  output logic               out_v,
  output logic [DW/2-1:0]    out_root,
  output logic [SW-1:0]      out_side
);
  localparam int RW  = DW / 2;
  localparam int RMW = RW + 2;

  logic          v_r    [RW];
  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [DW-1:0]  d_r    [RW];
  logic [SW-1:0]  side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic           v_s;
    logic [RMW-1:0] rem_s;
    logic [RW-1:0]  root_s;
    logic [DW-1:0]  d_s;
    logic [SW-1:0]  side_s;
    logic [RMW+1:0] t;
    logic [RMW+1:0] trial;
    logic [RMW-1:0] rem_nxt;
    logic [RW-1:0]  root_nxt;

    if (k == 0) begin : g_src0
      assign v_s = in_v;
      assign rem_s = '0;
      assign root_s = '0;
      assign d_s = in_d;
      assign side_s = in_side;
    end else begin : g_srck
      assign v_s = v_r[k-1];
      assign rem_s = rem_r[k-1];
      assign root_s = root_r[k-1];
      assign d_s = d_r[k-1];
      assign side_s = side_r[k-1];
    end

    always_comb begin
      t = {rem_s, d_s[DW-1:DW-2]};
      trial = {{(RMW-RW){1'b0}}, root_s, 2'b01};
      if (t >= trial) begin
        rem_nxt = RMW'(t - trial);
        root_nxt = {root_s[RW-2:0], 1'b1};
      end else begin
        rem_nxt = RMW'(t);
        root_nxt = {root_s[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_s;
      end
      if (en) begin
        rem_r[k] <= rem_nxt;
        root_r[k] <= root_nxt;
        d_r[k] <= {d_s[DW-3:0], 2'b00};
        side_r[k] <= side_s;
      end
    end
  end

  assign out_v = v_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_side = side_r[RW-1];
endmodule
`default_nettype wire

// ----- src/qrs_div.sv -----
// Pipelined restoring divider of magnitudes, one quotient bit per stage, signed saturation.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div #(
  parameter int NW   = 50,
  parameter int DENW = 34,
  parameter int W    = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_v,
  input  wire logic [NW-1:0]   in_num,
  input  wire logic [DENW-1:0] in_den,
  input  wire logic            in_neg,
  output logic [W-1:0]         out_q,
  output logic                 out_ovf
);
  logic            v_r    [NW];
  logic [DENW-1:0] rem_r  [NW];
  logic [NW-1:0]   quo_r  [NW];
  logic [NW-1:0]   num_r  [NW];
  logic [DENW-1:0] den_r  [NW];
  logic            neg_r  [NW];
  logic            numz_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic            v_s, neg_s, numz_s;
    logic [DENW-1:0] rem_s, den_s;
    logic [NW-1:0]   quo_s, num_s;
    logic [DENW:0]   t;
    logic [DENW-1:0] rem_nxt;
    logic            qbit;

    if (k == 0) begin : g_src0
      assign v_s = in_v;
      assign rem_s = '0;
      assign quo_s = '0;
      assign num_s = in_num;
      assign den_s = in_den;
      assign neg_s = in_neg;
      assign numz_s = (in_num == '0);
    end else begin : g_srck
      assign v_s = v_r[k-1];
      assign rem_s = rem_r[k-1];
      assign quo_s = quo_r[k-1];
      assign num_s = num_r[k-1];
      assign den_s = den_r[k-1];
      assign neg_s = neg_r[k-1];
      assign numz_s = numz_r[k-1];
    end

    always_comb begin
      t = {rem_s, num_s[NW-1]};
      qbit = (t >= {1'b0, den_s});
      rem_nxt = qbit ? DENW'(t - {1'b0, den_s}) : DENW'(t);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_s;
      end
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= {quo_s[NW-2:0], qbit};
        num_r[k] <= {num_s[NW-2:0], 1'b0};
        den_r[k] <= den_s;
        neg_r[k] <= neg_s;
        numz_r[k] <= numz_s;
      end
    end
  end

  logic [NW-1:0] quo_l, limit, mag;
  logic          ovf_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic          ovf_r;

  always_comb begin
    quo_l = quo_r[NW-1];
    limit = neg_r[NW-1] ? (NW'(1) << (W-1)) : ((NW'(1) << (W-1)) - NW'(1));
    ovf_nxt = 1'b0;
    mag = quo_l;
    if (den_r[NW-1] == '0) begin
      ovf_nxt = 1'b1;
      mag = numz_r[NW-1] ? '0 : limit;
    end else if (quo_l > limit) begin
      ovf_nxt = 1'b1;
      mag = limit;
    end
    q_nxt = neg_r[NW-1] ? W'(~mag + NW'(1)) : W'(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_q = q_r;
  assign out_ovf = ovf_r;
endmodule
`default_nettype wire

// ----- bench/tb_quadratic_root_solver_top.sv -----
// Self-checking testbench for the fixed-point quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
module tb_quadratic_root_solver_top;
  import qrs_pkg::*;

  localparam int W = WORD_BITS_DEF;
  localparam int F = FRACTION_BITS_DEF;
  localparam int LATENCY = 2 * W + F + 9;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [CFG_ADDR_W-1:0] ADDR_EPSILON = {REG_EPSILON, 2'b00};

  typedef struct packed {
    logic [W-1:0] c;
    logic [W-1:0] b;
    logic [W-1:0] a;
  } coef_t;

  typedef struct packed {
    logic         ovf;
    logic [W-1:0] r2;
    logic [W-1:0] r1;
    logic [1:0]   cnt;
  } roots_t;

  typedef struct {
    logic [W-1:0] a, b, c;
    logic         known;
    roots_t       res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  quadratic_root_solver_top dut (.*);

  always #5 clk = ~clk;

  logic [15:0] tol;
  roots_t      roots_due[$];
  int          mismatches = 0;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;

  function automatic logic [63:0] mag(logic [W-1:0] v);
    return v[W-1] ? 64'(-$signed(v)) : 64'(v);
  endfunction

  // truncating division on magnitudes, then saturate and sign
  function automatic logic [W-1:0] fx_div(logic [127:0] num, logic [63:0] den,
                                          logic neg, inout logic ovf);
    logic [127:0] q;
    logic [63:0]  lim;
    lim = neg ? 64'(1) << (W - 1) : (64'(1) << (W - 1)) - 1;
    if (den == 0) begin
      ovf = 1'b1;
      if (num == 0) return '0;
      q = 128'(lim);
    end else begin
      q = num / 128'(den);
      if (q > 128'(lim)) begin
        ovf = 1'b1;
        q = 128'(lim);
      end
    end
    return neg ? W'(-q) : W'(q);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] d);
    logic [63:0] r, cand;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (64'(1) << i);
      if (128'(cand) * 128'(cand) <= d) r = cand;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
    roots_t res;
    logic [63:0] ma, mb, mc, rt, mq;
    logic [127:0] bb, ac4, disc;
    logic sa, sb, sc, ovf, qneg;
    res = '0;
    ovf = 1'b0;
    sa = a[W-1]; sb = b[W-1]; sc = c[W-1];
    ma = mag(a); mb = mag(b); mc = mag(c);
    bb = 128'(mb) * 128'(mb);
    ac4 = (128'(ma) * 128'(mc)) << 2;
    if (sa != sc) disc = bb + ac4;
    else if (bb < ac4) return res;
    else disc = bb - ac4;
    if (disc < (128'(tol) << F)) return res;
    rt = isqrt(disc);
    if (mb > 64'(tol)) begin
      mq = mb + rt;
      qneg = ~sb;
      res.r1 = fx_div(128'(mq) << F, ma << 1, qneg != sa, ovf);
      res.r2 = fx_div(128'(mc << 1) << F, mq, sc != qneg, ovf);
      res.cnt = CNT_TWO;
    end else begin
      res.r1 = fx_div(128'(rt) << F, ma << 1, sa, ovf);
      res.cnt = CNT_ONE;
    end
    res.ovf = ovf;
    return res;
  endfunction

  task automatic cfg_write(logic [15:0] value);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_EPSILON; cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    tol = value;
  endtask

  task automatic send_coefs(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c,
                            logic known, roots_t res);
    coef_t beat;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    beat.a = a; beat.b = b; beat.c = c;
    in_tdata <= 96'(beat);
    in_tvalid <= 1'b1;
    roots_due.push_back(known ? res : solve_roots(a, b, c));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rnd_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return W'($signed($urandom_range(8 << F)) - (4 << F));
      2: return W'($signed($urandom_range(255)) - 128);
      3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return W'($signed($urandom_range(64)) - 32) << F;
    endcase
  endfunction

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    roots_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = roots_t'(out_tdata[2*W+2:0]);
      if (roots_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = roots_due.pop_front();
        if (got != want || out_tdata[71:2*W+3] != 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: cnt %0d/%0d r1 %h/%h r2 %h/%h ovf %b/%b (exp/got)",
                     want.cnt, got.cnt, want.r1, got.r1, want.r2, got.r2,
                     want.ovf, got.ovf);
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  row_t rows[$];

  task automatic add_row(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c,
                         logic known, logic [1:0] cnt, logic [W-1:0] r1,
                         logic [W-1:0] r2, logic ovf);
    row_t r;
    r.a = a; r.b = b; r.c = c; r.known = known;
    r.res.cnt = cnt; r.res.r1 = r1; r.res.r2 = r2; r.res.ovf = ovf;
    rows.push_back(r);
  endtask

  initial begin
    logic [15:0] eps_set[4];
    tol = EPS_RESET;
    eps_set = '{16'd0, 16'hFFFF, 16'd300, 16'd1};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all zero: disc 0 below epsilon 1
    add_row('0, '0, '0, 1'b1, CNT_NONE, '0, '0, 1'b0);
    // x^2 - 1 = 0 with b within epsilon: single root sqrt(4)/2 = 1.0
    add_row(32'h0001_0000, '0, 32'hFFFF_0000, 1'b1, CNT_ONE, 32'h0001_0000, '0, 1'b0);
    // negative discriminant: x^2 + 1
    add_row(32'h0001_0000, '0, 32'h0001_0000, 1'b1, CNT_NONE, '0, '0, 1'b0);
    // zero a, b = 1.0, c = 0: q = -1, root q/0 saturates negative
    add_row('0, 32'h0001_0000, '0, 1'b1, CNT_TWO, 32'h8000_0000, '0, 1'b1);
    add_row('0, 32'hFFFF_0000, 32'h0001_0000, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'h0000_0100, 32'h0000_0002, 32'hFFF0_0000, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, CNT_NONE, '0, '0, 1'b0);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, CNT_NONE, '0, '0, 1'b0);
    foreach (rows[i]) send_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].known, rows[i].res);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(eps_set[ph]);
      for (int ip = 0; ip < 3; ip++) begin
        send_idle_pct = (ip == 0) ? 19 : (ip == 1) ? 80 : 0;
        recv_idle_pct = (ip == 0) ? 80 : (ip == 1) ? 19 : 0;
        if (ph == 0 && ip == 2) hold_cycles = 3 * LATENCY;
        for (int n = 0; n < 165; n++)
          send_coefs(rnd_coef(), rnd_coef(), rnd_coef(), 1'b0, '0);
      end
      drain();
    end

    if (mismatches == 0 && roots_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
